### hw/rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package qvr_pkg;

  localparam int COORD_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int QUAT_BITS      = 18;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qvr_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic signed [COORD_BITS-1:0] rotated_z;
    logic                         clipped;
  } result_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } quat_t;

endpackage

`default_nettype wire

### hw/rtl/qvr_datapath.sv
// Four-stage arithmetic pipeline: q*v products, round, t*conj(q) products,
// round and saturate. Depends on qvr_pkg.
`default_nettype none

module qvr_datapath #(
  parameter int FRAC_BITS = qvr_pkg::FRAC_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire qvr_pkg::point_t in_point,
  input  wire qvr_pkg::quat_t  quat,
  output logic                 out_valid,
  output qvr_pkg::result_t     out_result
);
  import qvr_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int Q    = QUAT_BITS;
  localparam int F    = FRAC_BITS;
  localparam int P1W  = Q + C;
  localparam int S1W  = P1W + 2;
  localparam int IW   = S1W - F;
  localparam int P2W  = IW + Q;
  localparam int S2W  = P2W + 2;
  localparam int S2X  = (S2W > C + F) ? S2W : C + F + 1;
  localparam int RX   = S2X - F;

  localparam logic signed [S1W-1:0] HALF1   = S1W'(1) <<< (F - 1);
  localparam logic signed [S2X-1:0] HALF2   = S2X'(1) <<< (F - 1);
  localparam logic signed [C-1:0]   SAT_MAX = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0]   SAT_MIN = {1'b1, {(C-1){1'b0}}};

  // stage valids: products1, intermediate, products2
  logic                  v1, v2, v3;
  logic signed [P1W-1:0] p1      [12];
  logic signed [P1W-1:0] p1_next [12];
  logic signed [IW-1:0]  iv      [4];
  logic signed [IW-1:0]  iv_next [4];
  logic signed [P2W-1:0] p2      [12];
  logic signed [P2W-1:0] p2_next [12];
  logic signed [S1W-1:0] s1      [4];
  logic signed [S2X-1:0] s2      [3];
  logic signed [RX-1:0]  r2      [3];
  logic signed [C-1:0]   sat     [3];
  logic [2:0]            clip;
  result_t               out_next;

  // stage 1: t = q * (0, p)
  always_comb begin
    p1_next[0]  = P1W'(quat.quat_w) * P1W'(in_point.point_x);
    p1_next[1]  = P1W'(quat.quat_y) * P1W'(in_point.point_z);
    p1_next[2]  = P1W'(quat.quat_z) * P1W'(in_point.point_y);
    p1_next[3]  = P1W'(quat.quat_w) * P1W'(in_point.point_y);
    p1_next[4]  = P1W'(quat.quat_z) * P1W'(in_point.point_x);
    p1_next[5]  = P1W'(quat.quat_x) * P1W'(in_point.point_z);
    p1_next[6]  = P1W'(quat.quat_w) * P1W'(in_point.point_z);
    p1_next[7]  = P1W'(quat.quat_x) * P1W'(in_point.point_y);
    p1_next[8]  = P1W'(quat.quat_y) * P1W'(in_point.point_x);
    p1_next[9]  = P1W'(quat.quat_x) * P1W'(in_point.point_x);
    p1_next[10] = P1W'(quat.quat_y) * P1W'(in_point.point_y);
    p1_next[11] = P1W'(quat.quat_z) * P1W'(in_point.point_z);
  end

  // stage 2: sum and round (ix, iy, iz, iw)
  always_comb begin
    s1[0] = S1W'(p1[0]) + S1W'(p1[1]) - S1W'(p1[2]);
    s1[1] = S1W'(p1[3]) + S1W'(p1[4]) - S1W'(p1[5]);
    s1[2] = S1W'(p1[6]) + S1W'(p1[7]) - S1W'(p1[8]);
    s1[3] = -S1W'(p1[9]) - S1W'(p1[10]) - S1W'(p1[11]);
    for (int k = 0; k < 4; k++) begin
      iv_next[k] = IW'((s1[k] + HALF1) >>> F);
    end
  end

  // stage 3: t * conj(q)
  always_comb begin
    p2_next[0]  = P2W'(iv[0]) * P2W'(quat.quat_w);
    p2_next[1]  = P2W'(iv[3]) * P2W'(quat.quat_x);
    p2_next[2]  = P2W'(iv[1]) * P2W'(quat.quat_z);
    p2_next[3]  = P2W'(iv[2]) * P2W'(quat.quat_y);
    p2_next[4]  = P2W'(iv[1]) * P2W'(quat.quat_w);
    p2_next[5]  = P2W'(iv[3]) * P2W'(quat.quat_y);
    p2_next[6]  = P2W'(iv[2]) * P2W'(quat.quat_x);
    p2_next[7]  = P2W'(iv[0]) * P2W'(quat.quat_z);
    p2_next[8]  = P2W'(iv[2]) * P2W'(quat.quat_w);
    p2_next[9]  = P2W'(iv[3]) * P2W'(quat.quat_z);
    p2_next[10] = P2W'(iv[0]) * P2W'(quat.quat_y);
    p2_next[11] = P2W'(iv[1]) * P2W'(quat.quat_x);
  end

  // stage 4: sum, round, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2[k] = S2X'(p2[4*k]) - S2X'(p2[4*k+1]) - S2X'(p2[4*k+2]) + S2X'(p2[4*k+3]);
      r2[k] = RX'((s2[k] + HALF2) >>> F);
      if ((&r2[k][RX-1:C-1]) || !(|r2[k][RX-1:C-1])) begin
        sat[k]  = C'(r2[k]);
        clip[k] = 1'b0;
      end else begin
        sat[k]  = r2[k][RX-1] ? SAT_MIN : SAT_MAX;
        clip[k] = 1'b1;
      end
    end
    out_next.rotated_x = sat[0];
    out_next.rotated_y = sat[1];
    out_next.rotated_z = sat[2];
    out_next.clipped   = |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1         <= p1_next;
      iv         <= iv_next;
      p2         <= p2_next;
      out_result <= out_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/quaternion_vector_rotate.sv
// Quaternion point rotation, top level: configuration registers and flow
// control around the arithmetic pipeline. Depends on qvr_pkg, qvr_datapath.
//
// Usage:
//   Input channel point_valid / point_stall / point carries one 3D point
//   (signed fixed point) per transaction. Output channel result_valid /
//   result_stall / result carries the rotated point and a clipped flag.
//   The quaternion is written through cfg_we / cfg_index / cfg_data; the
//   user must do so only while no transaction is in flight, since the block
//   does not enforce it. Throughput is one point per cycle while the result
//   is not stalled. The four register stages are set by the two multiply
//   layers and the two add/round layers of the q*v*conj(q) product.
//   Reset clears all stage valids and loads the identity quaternion.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   point_stall is raised in the same cycle; nothing is dropped or repeated.
`default_nettype none

module quaternion_vector_rotate #(
  parameter int FRAC_BITS = qvr_pkg::FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                point_valid,
  output logic                                     point_stall,
  input  wire qvr_pkg::point_t                     point,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output qvr_pkg::result_t                         result,
  input  wire logic                                cfg_we,
  input  wire logic [qvr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [qvr_pkg::QUAT_BITS-1:0]       cfg_data
);
  import qvr_pkg::*;

  quat_t quat;
  logic  en;

  assign en          = !(result_valid && result_stall);
  assign point_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.quat_w <= QUAT_BITS'(1) <<< FRAC_BITS;
      quat.quat_x <= '0;
      quat.quat_y <= '0;
      quat.quat_z <= '0;
    end else if (cfg_we) begin
      unique case (qvr_reg_e'(cfg_index))
        REG_QUAT_W: quat.quat_w <= cfg_data;
        REG_QUAT_X: quat.quat_x <= cfg_data;
        REG_QUAT_Y: quat.quat_y <= cfg_data;
        REG_QUAT_Z: quat.quat_z <= cfg_data;
        default: ;
      endcase
    end
  end

  qvr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (point_valid),
    .in_point   (point),
    .quat       (quat),
    .out_valid  (result_valid),
    .out_result (result)
  );

endmodule

`default_nettype wire

### hw/rtl/qvr_checker.sv
// Port-level checks for quaternion_vector_rotate and the bind that attaches
// them. Depends on qvr_pkg and quaternion_vector_rotate.
`default_nettype none

module qvr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              point_valid,
  input wire logic              point_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire qvr_pkg::result_t  result
);
  import qvr_pkg::*;

  // a held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> result_valid && result_stall)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // an accepted point reaches result_valid while the output flows
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall && !result_stall) ##1 !result_stall
      ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("accepted transaction did not appear after four cycles");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_stall  (point_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### test/rotation_checker.sv
// Checker for quaternion_vector_rotate: watches both channels and the register port,
// predicts each rotated point from its own copy of the quaternion and compares field by field.
// Depends on qvr_pkg.
`timescale 1ns / 100ps

module rotation_checker
  import qvr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         point_valid,
  input  logic         point_stall,
  input  point_t       point,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_t      result,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [17:0]  cfg_data,
  output int           mismatches,
  output int           in_flight
);

  quat_t   quat;
  result_t expected_rotations[$];

  function automatic logic signed [127:0] round_half_up(input logic signed [127:0] acc);
    return (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [127:0] saturate(input logic signed [127:0] v, input int n);
    logic signed [127:0] ceiling;
    ceiling = (128'sd1 <<< (n - 1)) - 128'sd1;
    if (v > ceiling) return ceiling;
    if (v < -ceiling - 128'sd1) return -ceiling - 128'sd1;
    return v;
  endfunction

  // t = q * (0, p), then vector part of t * conj(q); exact sums, rounded per stage
  function automatic result_t rotate_point(input quat_t q, input point_t p);
    logic signed [127:0] w, qx, qy, qz, x, y, z, r, s;
    logic signed [127:0] inner[4];
    logic signed [127:0] outer[3];
    logic clip;
    result_t res;
    w  = $signed(q.quat_w);
    qx = $signed(q.quat_x);
    qy = $signed(q.quat_y);
    qz = $signed(q.quat_z);
    x  = $signed(p.point_x);
    y  = $signed(p.point_y);
    z  = $signed(p.point_z);
    clip = 1'b0;
    inner[0] = w * x + qy * z - qz * y;
    inner[1] = w * y + qz * x - qx * z;
    inner[2] = w * z + qx * y - qy * x;
    inner[3] = -(qx * x) - qy * y - qz * z;
    for (int i = 0; i < 4; i++) begin
      r = round_half_up(inner[i]);
      s = saturate(r, 64);
      clip |= (s != r);
      inner[i] = s;
    end
    outer[0] = inner[0] * w - inner[3] * qx - inner[1] * qz + inner[2] * qy;
    outer[1] = inner[1] * w - inner[3] * qy - inner[2] * qx + inner[0] * qz;
    outer[2] = inner[2] * w - inner[3] * qz - inner[0] * qy + inner[1] * qx;
    for (int i = 0; i < 3; i++) begin
      r = round_half_up(outer[i]);
      s = saturate(r, COORD_BITS);
      clip |= (s != r);
      outer[i] = s;
    end
    res.rotated_x = outer[0][COORD_BITS-1:0];
    res.rotated_y = outer[1][COORD_BITS-1:0];
    res.rotated_z = outer[2][COORD_BITS-1:0];
    res.clipped   = clip;
    return res;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    int      errs;
    result_t want;
    errs = 0;
    if (rst) begin
      quat = '{quat_w: 18'sd1 <<< FRAC_BITS, quat_x: '0, quat_y: '0, quat_z: '0};
      expected_rotations.delete();
      mismatches <= 0;
      in_flight  <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_rotations.size() == 0) begin
          $error("result transaction with no point pending");
          errs++;
        end else begin
          want = expected_rotations.pop_front();
          errs += field_differs("rotated_x", want.rotated_x, result.rotated_x);
          errs += field_differs("rotated_y", want.rotated_y, result.rotated_y);
          errs += field_differs("rotated_z", want.rotated_z, result.rotated_z);
          errs += field_differs("clipped", want.clipped, result.clipped);
        end
      end
      if (point_valid && !point_stall)
        expected_rotations.push_back(rotate_point(quat, point));
      if (cfg_we) begin
        case (qvr_reg_e'(cfg_index))
          REG_QUAT_W: quat.quat_w = cfg_data;
          REG_QUAT_X: quat.quat_x = cfg_data;
          REG_QUAT_Y: quat.quat_y = cfg_data;
          REG_QUAT_Z: quat.quat_z = cfg_data;
          default: ;
        endcase
      end
      mismatches <= mismatches + errs;
      in_flight  <= expected_rotations.size();
    end
  end

endmodule

### test/tb_top.sv
// Top of the quaternion_vector_rotate regression: clock, reset, point and quaternion stimulus,
// randomized receiver stalls. Depends on qvr_pkg, quaternion_vector_rotate, rotation_checker.
`timescale 1ns / 100ps

module tb_top;
  import qvr_pkg::*;

  localparam logic [31:0] COORD_MAX = 32'h7fffffff;
  localparam logic [31:0] COORD_MIN = 32'h80000000;
  localparam logic [17:0] QUAT_MAX  = 18'h1ffff;
  localparam logic [17:0] QUAT_MIN  = 18'h20000;
  localparam logic [17:0] QUAT_ONE  = 18'h10000;
  localparam logic [17:0] QUAT_HALF = 18'h08000;
  localparam logic [17:0] QUAT_COS45 = 18'd46341;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_POINTS  = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        point_valid = 1'b0;
  logic        point_stall;
  point_t      point = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_QUAT_W;
  logic [17:0] cfg_data = '0;
  int          mismatches;
  int          in_flight;
  bit          quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quaternion_vector_rotate DUT (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rotation_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .in_flight    (in_flight)
  );

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic point_t pt(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  function automatic quat_t qt(input logic [17:0] w, input logic [17:0] x,
                               input logic [17:0] y, input logic [17:0] z);
    quat_t q;
    q.quat_w = w;
    q.quat_x = x;
    q.quat_y = y;
    q.quat_z = z;
    return q;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] u;
    case ($urandom_range(0, 3))
      0: u = $urandom;
      1: u = $urandom_range(0, 2097152) - 1048576;
      2: begin
        case ($urandom_range(0, 4))
          0: u = COORD_MAX;
          1: u = COORD_MIN;
          2: u = 32'h0;
          3: u = 32'h1;
          default: u = 32'hffffffff;
        endcase
      end
      default: u = $urandom_range(0, 134217728) - 67108864;
    endcase
    return u;
  endfunction

  function automatic logic [17:0] rand_part(input int kind);
    logic [31:0] u;
    case (kind)
      0: u = $urandom_range(0, 18'h3ffff);
      1: u = $urandom_range(0, 92682) - 46341;
      default: begin
        case ($urandom_range(0, 2))
          0: u = QUAT_MAX;
          1: u = QUAT_MIN;
          default: u = 32'h0;
        endcase
      end
    endcase
    return u[17:0];
  endfunction

  task automatic send_point(input point_t p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point       <= p;
    do @(posedge clk); while (point_stall);
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_quat(input quat_t q);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUAT_W;
    cfg_data  <= q.quat_w;
    @(posedge clk);
    cfg_index <= REG_QUAT_X;
    cfg_data  <= q.quat_x;
    @(posedge clk);
    cfg_index <= REG_QUAT_Y;
    cfg_data  <= q.quat_y;
    @(posedge clk);
    cfg_index <= REG_QUAT_Z;
    cfg_data  <= q.quat_z;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stalls per transaction, one long hold-off to back up the pipeline
  initial begin
    int  n;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && taken == 400) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        n = draw_wait();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
          result_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  initial begin
    int    kind;
    quat_t q;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // identity from reset
    send_point(pt(32'h0, 32'h0, 32'h0));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(pt(COORD_MAX, COORD_MIN, 32'h1));
    send_point(pt(32'hffffffff, 32'h1, 32'hffffffff));
    drain();

    // half scale: ties round up
    load_quat(qt(QUAT_HALF, '0, '0, '0));
    send_point(pt(32'h1, 32'hffffffff, 32'h3));
    send_point(pt(32'hfffffffd, 32'h2, 32'h5));
    drain();

    // largest and smallest quaternions, saturation
    load_quat(qt(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(pt(32'h1, 32'h1, 32'h1));
    send_point(pt(32'h0, 32'h0, 32'h0));
    send_point(pt(32'h10000, 32'hffff0000, 32'h0));
    drain();
    load_quat(qt(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN));
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(pt(32'h1, 32'h1, 32'h1));
    send_point(pt(32'h0, 32'h0, 32'h0));
    send_point(pt(32'h10000, 32'hffff0000, 32'h0));
    drain();

    // quarter turn about z
    load_quat(qt(QUAT_COS45, '0, '0, QUAT_COS45));
    send_point(pt(32'h10000, 32'h0, 32'h0));
    send_point(pt(32'h0, 32'h10000, 32'h0));
    send_point(pt(COORD_MAX, 32'h0, COORD_MIN));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = $urandom_range(0, 2);
      q = qt(rand_part(kind), rand_part(kind), rand_part(kind), rand_part(kind));
      if (phase == 0)
        q = qt(QUAT_ONE, '0, '0, '0);
      else if (phase == 1)
        q = qt(rand_part(2), rand_part(2), rand_part(2), rand_part(2));
      else if (phase == 5)
        q = qt(QUAT_MIN, '0, '0, '0);
      load_quat(q);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_POINTS; i++)
        send_point(pt(rand_coord(), rand_coord(), rand_coord()));
      drain();
    end

    if (mismatches == 0)
      $display("quaternion_vector_rotate regression: pass");
    else
      $display("quaternion_vector_rotate regression: fail");
    $finish;
  end

  initial begin
    #1000000;
    $display("quaternion_vector_rotate regression: fail");
    $finish;
  end

endmodule
